// ===== sv/satr_pkg.sv =====
package satr_pkg;

    localparam int FUNC_W = 2;
    localparam int COORD_W = 10;
    localparam int DIM_W = 11;
    localparam int SMP_W = 16;
    localparam int BYTE_W = 8;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int P_W = 21;
    localparam int LVL_W = 17;
    localparam int TONE_STEPS = 16;

    localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESOLVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRGB = 2'd3;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic logic [7:0] q30_to_byte(input logic signed [65:0] e);
        logic [65:0] v;
        if (e < 0)
        begin
            return 8'd0;
        end
        v = ((66'(e) * 66'd255) + 66'(Q30_ONE >> 1)) >> 30;
        return (v > 66'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] srgb_entry(input logic [31:0] i, input int tb);
        logic [63:0] u;
        logic [63:0] thr;
        logic [63:0] u2;
        logic [63:0] u5;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] m2;
        logic [63:0] m4;
        logic [63:0] m8;
        logic signed [65:0] e;
        u = 64'(i) << (30 - tb);
        thr = (64'd31308 << 30) / 64'd10000000;
        if (u > Q30_ONE)
        begin
            u = Q30_ONE;
        end
        if (u <= thr)
        begin
            e = $signed({2'b00, (u * 64'd1292) / 64'd100});
            return q30_to_byte(e);
        end
        u2 = qmul(u, u);
        u5 = qmul(qmul(u2, u2), u);
        lo = 64'd0;
        hi = Q30_ONE;
        for (int s = 0; s < 32; s++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                m2 = qmul(mid, mid);
                m4 = qmul(m2, m2);
                m8 = qmul(m4, m4);
                if (qmul(m8, m4) <= u5)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 64'd1;
                end
            end
        end
        e = $signed({2'b00, (lo * 64'd1055) / 64'd1000})
            - $signed({2'b00, (64'd55 << 30) / 64'd1000});
        return q30_to_byte(e);
    endfunction

endpackage

// ===== sv/satr_div.sv =====
module satr_div #(
    parameter int QW = 40,
    parameter int DW = 41
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [$clog2(QW+1)-1:0]  steps,
    input  logic [DW-1:0]            rem_init,
    input  logic [QW-1:0]            num,
    input  logic [DW-1:0]            den,
    output logic                     busy,
    output logic [QW-1:0]            quo
);
    localparam int SW = $clog2(QW + 1);

    logic          busy_reg;
    logic [SW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] q_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   r2;
    logic          ge;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] q_next;

    always_comb
    begin
        r2 = {rem_reg, q_reg[QW-1]};
        ge = r2 >= {1'b0, den_reg};
        rem_next = ge ? DW'(r2 - {1'b0, den_reg}) : r2[DW-1:0];
        q_next = {q_reg[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - SW'(1);
            if (cnt_reg == SW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            q_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg <= q_next;
        end
    end

    assign busy = busy_reg;
    assign quo = q_reg;

endmodule

// ===== sv/satr_mem.sv =====
module satr_mem #(
    parameter int DEPTH = 65536,
    parameter int W = 112
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [W-1:0]                           wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [W-1:0]                           rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/satr_fmt.sv =====
module satr_fmt #(
    parameter int TB = 12
) (
    input  logic                          clk,
    input  logic [satr_pkg::LVL_W-1:0]    level,
    input  logic                          srgb,
    output logic [satr_pkg::BYTE_W-1:0]   byte_out
);
    import satr_pkg::*;

    localparam int TLEN = (1 << TB) + 1;
    localparam int IW = LVL_W + TB + 1;

    function automatic logic [TLEN*8-1:0] build_rom();
        logic [TLEN*8-1:0] r;
        r = '0;
        for (int k = 0; k < TLEN; k++)
        begin
            r[k*8 +: 8] = srgb_entry(32'(k), TB);
        end
        return r;
    endfunction

    localparam logic [TLEN*8-1:0] ROM = build_rom();

    logic [24:0]       lin_full;
    logic [IW-1:0]     idx_full;
    logic [TB:0]       idx;
    logic [BYTE_W-1:0] byte_reg;

    always_comb
    begin
        lin_full = (25'(level) * 25'd255 + 25'd32768) >> 16;
        idx_full = (IW'(level) << TB) + IW'(32768);
        idx = idx_full[16 +: TB + 1];
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= srgb ? ROM[{idx, 3'b000} +: 8] : lin_full[7:0];
    end

    assign byte_out = byte_reg;

endmodule

// ===== sv/sample_accumulate_tonemap_resolve.sv =====
// Per-pixel film buffer: add items accumulate a Q8.8 RGB sample into one pixel, resolve items
// return average -> optional Reinhard -> clamp -> optional sRGB -> 8-bit bytes, clear items zero
// the store. Accesses go through one read port and one write port of the pixel memory, and resolve
// math runs on one shared restoring divider at one quotient bit per cycle. An add passes through
// index, read and execute states, and an out-of-range, clear or unused-code item skips the read;
// a resolve runs an average division, an optional Reinhard division and formatting per channel,
// and a pixel with no samples skips the average division. After reset, after a clear item and
// after a write of frame_width or frame_height the store is swept to zero, one pixel per cycle
// over all MAX_PIXELS addresses, and in_stall stays high meanwhile; a width or height write
// during a sweep restarts it. Configuration writes are always taken (cfg_ready is tied high).
module sample_accumulate_tonemap_resolve #(
    parameter int MAX_PIXELS = 65536,
    parameter int COUNT_BITS = 16,
    parameter int SRGB_TABLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [satr_pkg::FUNC_W-1:0]       func,
    input  logic [satr_pkg::COORD_W-1:0]      pixel_x,
    input  logic [satr_pkg::COORD_W-1:0]      pixel_y,
    input  logic [satr_pkg::SMP_W-1:0]        red,
    input  logic [satr_pkg::SMP_W-1:0]        green,
    input  logic [satr_pkg::SMP_W-1:0]        blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [satr_pkg::STATUS_W-1:0]     status,
    output logic [satr_pkg::BYTE_W-1:0]       red8,
    output logic [satr_pkg::BYTE_W-1:0]       green8,
    output logic [satr_pkg::BYTE_W-1:0]       blue8,
    output logic [satr_pkg::TOTAL_W-1:0]      sample_total,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [satr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [satr_pkg::DIM_W-1:0]        cfg_data
);
    import satr_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SUM_W = SMP_W + COUNT_BITS;
    localparam int A_W = SUM_W + 8;
    localparam int DW = A_W + 1;
    localparam int SW = $clog2(A_W + 1);
    localparam int WORD_W = COUNT_BITS + 3 * SUM_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INDEX = 4'd1;
    localparam logic [3:0] S_READ = 4'd2;
    localparam logic [3:0] S_EXEC = 4'd3;
    localparam logic [3:0] S_AVG = 4'd4;
    localparam logic [3:0] S_AVGW = 4'd5;
    localparam logic [3:0] S_TONE = 4'd6;
    localparam logic [3:0] S_TONEW = 4'd7;
    localparam logic [3:0] S_FMT = 4'd8;
    localparam logic [3:0] S_FMTW = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_BITS-1:0] c);
        return (32'(c) > 32'd65535) ? '1 : TOTAL_W'(c);
    endfunction

    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic                  clearing_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic                  out_valid_reg;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic                  tone_reg;
    logic                  srgb_reg;

    logic [FUNC_W-1:0]     func_reg;
    logic [COORD_W-1:0]    x_reg;
    logic [COORD_W-1:0]    y_reg;
    logic [SMP_W-1:0]      r_smp_reg;
    logic [SMP_W-1:0]      g_smp_reg;
    logic [SMP_W-1:0]      b_smp_reg;
    logic [AW-1:0]         p_reg;
    logic [1:0]            ch_reg;
    logic [A_W-1:0]        a_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [TOTAL_W-1:0]    res_total_reg;
    logic [BYTE_W-1:0]     res_r_reg;
    logic [BYTE_W-1:0]     res_g_reg;
    logic [BYTE_W-1:0]     res_b_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [BYTE_W-1:0]     r8_reg;
    logic [BYTE_W-1:0]     g8_reg;
    logic [BYTE_W-1:0]     b8_reg;

    logic                  in_accept;
    logic                  out_load;
    logic                  cfg_write;
    logic                  clear_start;
    logic [P_W-1:0]        p_full;
    logic                  oor;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic                  mem_re;
    logic [WORD_W-1:0]     mem_rdata;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [SUM_W-1:0]      rd_rsum;
    logic [SUM_W-1:0]      rd_gsum;
    logic [SUM_W-1:0]      rd_bsum;
    logic [SUM_W-1:0]      sum_sel;
    logic                  is_add;
    logic                  cnt_full;
    logic                  div_start;
    logic [SW-1:0]         div_steps;
    logic [DW-1:0]         div_rem;
    logic [A_W-1:0]        div_num;
    logic [DW-1:0]         div_den;
    logic                  div_busy;
    logic [A_W-1:0]        div_quo;
    logic [LVL_W-1:0]      level;
    logic [BYTE_W-1:0]     fmt_byte;

    assign in_stall = (state_reg != S_IDLE) || clearing_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign clear_start = ((state_reg == S_INDEX) && (func_reg == FUNC_CLEAR))
        || (cfg_write && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT)));

    always_comb
    begin
        p_full = P_W'(y_reg) * P_W'(width_reg) + P_W'(x_reg);
        oor = (DIM_W'(x_reg) >= width_reg) || (DIM_W'(y_reg) >= height_reg)
            || ({1'b0, p_full} >= (P_W + 1)'(MAX_PIXELS));
        rd_rsum = mem_rdata[0 +: SUM_W];
        rd_gsum = mem_rdata[SUM_W +: SUM_W];
        rd_bsum = mem_rdata[2 * SUM_W +: SUM_W];
        rd_cnt = mem_rdata[3 * SUM_W +: COUNT_BITS];
        is_add = func_reg == FUNC_ADD;
        cnt_full = rd_cnt == COUNT_MAX;
        case (ch_reg)
            2'd0: sum_sel = rd_rsum;
            2'd1: sum_sel = rd_gsum;
            default: sum_sel = rd_bsum;
        endcase
        level = (a_reg > A_W'(65536)) ? LVL_W'(65536) : a_reg[LVL_W-1:0];
    end

    always_comb
    begin
        mem_re = state_reg == S_READ;
        if (clearing_reg)
        begin
            mem_we = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we = (state_reg == S_EXEC) && is_add && !cnt_full;
            mem_waddr = p_reg;
            mem_wdata = {rd_cnt + COUNT_BITS'(1),
                         rd_bsum + SUM_W'(b_smp_reg),
                         rd_gsum + SUM_W'(g_smp_reg),
                         rd_rsum + SUM_W'(r_smp_reg)};
        end
    end

    always_comb
    begin
        div_start = ((state_reg == S_AVG) && (rd_cnt != '0))
            || ((state_reg == S_TONE) && tone_reg);
        if (state_reg == S_AVG)
        begin
            div_steps = SW'(A_W);
            div_rem = '0;
            div_num = {sum_sel, 8'd0};
            div_den = DW'(rd_cnt);
        end
        else
        begin
            div_steps = SW'(TONE_STEPS);
            div_rem = DW'(a_reg);
            div_num = '0;
            div_den = DW'(a_reg) + DW'(65536);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_INDEX;
                end
            end
            S_INDEX:
            begin
                if ((func_reg == FUNC_ADD || func_reg == FUNC_RESOLVE) && !oor)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ: state_next = S_EXEC;
            S_EXEC: state_next = is_add ? S_DONE : S_AVG;
            S_AVG: state_next = (rd_cnt != '0) ? S_AVGW : S_TONE;
            S_AVGW:
            begin
                if (!div_busy)
                begin
                    state_next = S_TONE;
                end
            end
            S_TONE: state_next = tone_reg ? S_TONEW : S_FMT;
            S_TONEW:
            begin
                if (!div_busy)
                begin
                    state_next = S_FMT;
                end
            end
            S_FMT: state_next = S_FMTW;
            S_FMTW: state_next = (ch_reg == 2'd2) ? S_DONE : S_AVG;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            out_valid_reg <= 1'b0;
            width_reg <= '0;
            height_reg <= '0;
            tone_reg <= 1'b0;
            srgb_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear_start)
            begin
                clearing_reg <= 1'b1;
                clr_addr_reg <= '0;
            end
            else if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_PIXELS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_WIDTH: width_reg <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_TONE: tone_reg <= cfg_data[0];
                    REG_SRGB: srgb_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_reg <= func;
                    x_reg <= pixel_x;
                    y_reg <= pixel_y;
                    r_smp_reg <= red;
                    g_smp_reg <= green;
                    b_smp_reg <= blue;
                    res_status_reg <= ST_OK;
                    res_total_reg <= '0;
                    res_r_reg <= '0;
                    res_g_reg <= '0;
                    res_b_reg <= '0;
                end
            end
            S_INDEX:
            begin
                p_reg <= p_full[AW-1:0];
                if ((func_reg == FUNC_ADD || func_reg == FUNC_RESOLVE) && oor)
                begin
                    res_status_reg <= ST_OOR;
                end
            end
            S_EXEC:
            begin
                ch_reg <= 2'd0;
                if (is_add && cnt_full)
                begin
                    res_status_reg <= ST_DROP;
                    res_total_reg <= sat_total(rd_cnt);
                end
                else if (is_add)
                begin
                    res_total_reg <= sat_total(rd_cnt + COUNT_BITS'(1));
                end
                else
                begin
                    res_total_reg <= sat_total(rd_cnt);
                end
            end
            S_AVG:
            begin
                if (rd_cnt == '0)
                begin
                    a_reg <= '0;
                end
            end
            S_AVGW, S_TONEW:
            begin
                if (!div_busy)
                begin
                    a_reg <= div_quo;
                end
            end
            S_FMTW:
            begin
                case (ch_reg)
                    2'd0: res_r_reg <= fmt_byte;
                    2'd1: res_g_reg <= fmt_byte;
                    default: res_b_reg <= fmt_byte;
                endcase
                ch_reg <= ch_reg + 2'd1;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    status_reg <= res_status_reg;
                    total_reg <= res_total_reg;
                    r8_reg <= res_r_reg;
                    g8_reg <= res_g_reg;
                    b8_reg <= res_b_reg;
                end
            end
            default: ;
        endcase
    end

    satr_mem #(
        .DEPTH (MAX_PIXELS),
        .W     (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (p_reg),
        .rdata (mem_rdata)
    );

    satr_div #(
        .QW (A_W),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .rem_init (div_rem),
        .num      (div_num),
        .den      (div_den),
        .busy     (div_busy),
        .quo      (div_quo)
    );

    satr_fmt #(
        .TB (SRGB_TABLE_BITS)
    ) u_fmt (
        .clk      (clk),
        .level    (level),
        .srgb     (srgb_reg),
        .byte_out (fmt_byte)
    );

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign red8 = r8_reg;
    assign green8 = g8_reg;
    assign blue8 = b8_reg;
    assign sample_total = total_reg;

    a_exec_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> !clearing_reg)
        else $error("pixel access during clearing pass");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OOR)
        |-> (r8_reg == '0 && g8_reg == '0 && b8_reg == '0 && total_reg == '0))
        else $error("out-of-range beat carries data");

    a_resolve_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(state_reg) == S_READ)
        else $error("pixel word used without a read");

endmodule
